FILE: hw/rtl/bpra_pkg.sv
// Shared types, constants and helpers for the button press repeat accelerator.
// Used by every module in hw/rtl; depends on nothing else.
package bpra_pkg;

   localparam int NUM_BUTTONS = 3;
   localparam int TICK_BITS   = 32;
   localparam int BTN_BITS    = (NUM_BUTTONS > 2) ? $clog2(NUM_BUTTONS) : 1;
   localparam int CMP_BITS    = (TICK_BITS > 32) ? TICK_BITS : 32;
   localparam int COUNT_BITS  = 5;
   localparam int SEL_BITS    = 2;
   localparam int ADDR_BITS   = 5;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR    = 2;

   localparam logic [COUNT_BITS-1:0] MID_COUNT  = COUNT_BITS'(10);
   localparam logic [COUNT_BITS-1:0] FAST_COUNT = COUNT_BITS'(20);

   typedef logic [TICK_BITS-1:0] tick_type;
   typedef logic [CMP_BITS-1:0]  cmp_type;
   typedef logic [BTN_BITS-1:0]  btn_idx_type;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_REPEAT = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_STATUS    = 2'd0,
      KIND_STEP      = 2'd1,
      KIND_BAD_INDEX = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CLASS_OFF   = 2'd0,
      CLASS_SHORT = 2'd1,
      CLASS_LONG  = 2'd2
   } press_class_type;

   typedef enum logic [2:0] {
      REG_LONG_THRESHOLD   = 3'd0,
      REG_REPEAT_INTERVAL  = 3'd1,
      REG_FIRST_STEP_SLOW  = 3'd2,
      REG_FIRST_STEP_MID   = 3'd3,
      REG_FIRST_STEP_FAST  = 3'd4,
      REG_SECOND_STEP_SLOW = 3'd5,
      REG_SECOND_STEP_MID  = 3'd6,
      REG_SECOND_STEP_FAST = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic                cmd;
      logic [SEL_BITS-1:0] button_sel;
      logic                level;
      logic [31:0]         now_ticks;
   } req_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [SEL_BITS-1:0] which_button;
      logic [1:0]          press_class;
      logic [15:0]         step_amount;
      logic                last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [31:0] long_threshold;
      logic [31:0] repeat_interval;
      logic [15:0] first_step_slow;
      logic [15:0] first_step_mid;
      logic [15:0] first_step_fast;
      logic [15:0] second_step_slow;
      logic [15:0] second_step_mid;
      logic [15:0] second_step_fast;
   } cfg_type;

   // results of one processed item, written into the response queue together
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic tick_type to_tick(input logic [31:0] value);
      tick_type result;
      for (int i = 0; i < TICK_BITS; i++) begin
         result[i] = (i < 32) ? value[i] : 1'b0;
      end
      return result;
   endfunction

   function automatic cmp_type tick_to_cmp(input tick_type value);
      cmp_type result;
      for (int i = 0; i < CMP_BITS; i++) begin
         result[i] = (i < TICK_BITS) ? value[i] : 1'b0;
      end
      return result;
   endfunction

   function automatic cmp_type word_to_cmp(input logic [31:0] value);
      cmp_type result;
      for (int i = 0; i < CMP_BITS; i++) begin
         result[i] = (i < 32) ? value[i] : 1'b0;
      end
      return result;
   endfunction

   function automatic btn_idx_type sel_to_idx(input logic [SEL_BITS-1:0] sel);
      btn_idx_type result;
      for (int i = 0; i < BTN_BITS; i++) begin
         result[i] = (i < SEL_BITS) ? sel[i] : 1'b0;
      end
      return result;
   endfunction

endpackage

FILE: hw/rtl/bpra_csr.sv
// Configuration register file with an APB-style access port.
// Depends on bpra_pkg for the register index codes and cfg_type.
module bpra_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [bpra_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output bpra_pkg::cfg_type          cfg
);
   import bpra_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign pready  = 1'b1;
   assign reg_idx = reg_index_type'(paddr[ADDR_BITS-1:2]);
   assign wr_en   = psel & penable & pwrite & pready;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_LONG_THRESHOLD:   cfg_in.long_threshold   = pwdata;
            REG_REPEAT_INTERVAL:  cfg_in.repeat_interval  = pwdata;
            REG_FIRST_STEP_SLOW:  cfg_in.first_step_slow  = pwdata[15:0];
            REG_FIRST_STEP_MID:   cfg_in.first_step_mid   = pwdata[15:0];
            REG_FIRST_STEP_FAST:  cfg_in.first_step_fast  = pwdata[15:0];
            REG_SECOND_STEP_SLOW: cfg_in.second_step_slow = pwdata[15:0];
            REG_SECOND_STEP_MID:  cfg_in.second_step_mid  = pwdata[15:0];
            REG_SECOND_STEP_FAST: cfg_in.second_step_fast = pwdata[15:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_LONG_THRESHOLD:   prdata = cfg_ff.long_threshold;
         REG_REPEAT_INTERVAL:  prdata = cfg_ff.repeat_interval;
         REG_FIRST_STEP_SLOW:  prdata = {16'd0, cfg_ff.first_step_slow};
         REG_FIRST_STEP_MID:   prdata = {16'd0, cfg_ff.first_step_mid};
         REG_FIRST_STEP_FAST:  prdata = {16'd0, cfg_ff.first_step_fast};
         REG_SECOND_STEP_SLOW: prdata = {16'd0, cfg_ff.second_step_slow};
         REG_SECOND_STEP_MID:  prdata = {16'd0, cfg_ff.second_step_mid};
         REG_SECOND_STEP_FAST: prdata = {16'd0, cfg_ff.second_step_fast};
         default:              prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_threshold   <= 32'd1000;
         cfg_ff.repeat_interval  <= 32'd250;
         cfg_ff.first_step_slow  <= 16'd1;
         cfg_ff.first_step_mid   <= 16'd5;
         cfg_ff.first_step_fast  <= 16'd10;
         cfg_ff.second_step_slow <= 16'd1;
         cfg_ff.second_step_mid  <= 16'd2;
         cfg_ff.second_step_fast <= 16'd4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/bpra_core.sv
// Per-button press state and the single-pass update for one item.
// Depends on bpra_pkg; produces up to two results per processed item.
module bpra_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  bpra_pkg::req_type  item,
   input  bpra_pkg::cfg_type  cfg,
   output bpra_pkg::push_type push
);
   import bpra_pkg::*;

   tick_type        press_start_ff   [NUM_BUTTONS];
   tick_type        press_start_in   [NUM_BUTTONS];
   logic            prev_level_ff    [NUM_BUTTONS];
   logic            prev_level_in    [NUM_BUTTONS];
   logic            class_pending_ff [NUM_BUTTONS];
   logic            class_pending_in [NUM_BUTTONS];
   press_class_type press_state_ff   [NUM_BUTTONS];
   press_class_type press_state_in   [NUM_BUTTONS];
   tick_type        last_repeat_ff   [2];
   tick_type        last_repeat_in   [2];
   logic [COUNT_BITS-1:0] repeat_count_ff [2];
   logic [COUNT_BITS-1:0] repeat_count_in [2];

   tick_type        now_t;
   btn_idx_type     idx;
   logic            bad_sel;
   tick_type        age;
   logic            rep_emit [2];
   rsp_type         rep_rsp  [2];
   rsp_type         stat_rsp;

   assign now_t   = to_tick(item.now_ticks);
   assign idx     = sel_to_idx(item.button_sel);
   assign bad_sel = ({2'b00, item.button_sel} >= 4'(NUM_BUTTONS));

   function automatic logic [15:0] pick_step(input cfg_type c, input logic second,
                                             input logic mid, input logic fast);
      logic [15:0] step;
      if (second) begin
         step = fast ? c.second_step_fast : (mid ? c.second_step_mid : c.second_step_slow);
      end else begin
         step = fast ? c.first_step_fast : (mid ? c.first_step_mid : c.first_step_slow);
      end
      return step;
   endfunction

   always_comb begin
      press_start_in   = press_start_ff;
      prev_level_in    = prev_level_ff;
      class_pending_in = class_pending_ff;
      press_state_in   = press_state_ff;
      last_repeat_in   = last_repeat_ff;
      repeat_count_in  = repeat_count_ff;
      age              = '0;
      stat_rsp         = '0;
      for (int b = 0; b < 2; b++) begin
         rep_emit[b] = 1'b0;
         rep_rsp[b]  = '0;
      end

      if (item.cmd == CMD_SAMPLE) begin
         if (!bad_sel) begin
            // rising level: start timing a new press
            if (item.level && !prev_level_ff[idx]) begin
               prev_level_in[idx]    = 1'b1;
               press_start_in[idx]   = now_t;
               class_pending_in[idx] = 1'b1;
            end
            if (!item.level) begin
               prev_level_in[idx] = 1'b0;
               if (press_state_ff[idx] == CLASS_LONG) begin
                  press_state_in[idx] = CLASS_OFF;
               end
            end
            age = now_t - press_start_in[idx];
            if (class_pending_in[idx] &&
                (tick_to_cmp(age) > word_to_cmp(cfg.long_threshold))) begin
               class_pending_in[idx] = 1'b0;
               press_state_in[idx]   = item.level ? CLASS_LONG : CLASS_SHORT;
            end
         end
      end else begin
         for (int b = 0; b < 2; b++) begin
            case (press_state_ff[b])
               CLASS_SHORT: begin
                  press_state_in[b]       = CLASS_OFF;
                  rep_emit[b]             = 1'b1;
                  rep_rsp[b].kind         = KIND_STEP;
                  rep_rsp[b].which_button = SEL_BITS'(b);
                  rep_rsp[b].press_class  = CLASS_OFF;
                  rep_rsp[b].step_amount  = pick_step(cfg, b[0], 1'b0, 1'b0);
               end
               CLASS_LONG: begin
                  if (tick_to_cmp(now_t - last_repeat_ff[b]) >
                      word_to_cmp(cfg.repeat_interval)) begin
                     if (repeat_count_ff[b] < FAST_COUNT) begin
                        repeat_count_in[b] = repeat_count_ff[b] + COUNT_BITS'(1);
                     end
                     last_repeat_in[b]       = now_t;
                     rep_emit[b]             = 1'b1;
                     rep_rsp[b].kind         = KIND_STEP;
                     rep_rsp[b].which_button = SEL_BITS'(b);
                     rep_rsp[b].press_class  = CLASS_LONG;
                     rep_rsp[b].step_amount  = pick_step(cfg, b[0],
                        (repeat_count_ff[b] >= MID_COUNT) && (repeat_count_ff[b] < FAST_COUNT),
                        repeat_count_ff[b] >= FAST_COUNT);
                  end
               end
               default: begin
                  repeat_count_in[b] = '0;
               end
            endcase
         end
      end

      if (bad_sel) begin
         stat_rsp.kind         = KIND_BAD_INDEX;
         stat_rsp.press_class  = CLASS_OFF;
      end else begin
         stat_rsp.kind         = KIND_STATUS;
         stat_rsp.press_class  = press_state_in[idx];
      end
      stat_rsp.which_button = item.button_sel;
      stat_rsp.step_amount  = 16'd0;
      stat_rsp.last_of_run  = 1'b1;
   end

   // pack results in button order; the final one carries last_of_run
   always_comb begin
      push = '0;
      if (item.cmd == CMD_SAMPLE) begin
         push.count = 2'd1;
         push.first = stat_rsp;
      end else if (rep_emit[0] && rep_emit[1]) begin
         push.count              = 2'd2;
         push.first              = rep_rsp[0];
         push.second             = rep_rsp[1];
         push.second.last_of_run = 1'b1;
      end else if (rep_emit[0] || rep_emit[1]) begin
         push.count             = 2'd1;
         push.first             = rep_emit[0] ? rep_rsp[0] : rep_rsp[1];
         push.first.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            press_start_ff[b]   <= '0;
            prev_level_ff[b]    <= 1'b0;
            class_pending_ff[b] <= 1'b0;
            press_state_ff[b]   <= CLASS_OFF;
         end
         for (int b = 0; b < 2; b++) begin
            last_repeat_ff[b]  <= '0;
            repeat_count_ff[b] <= '0;
         end
      end else if (fire) begin
         press_start_ff   <= press_start_in;
         prev_level_ff    <= prev_level_in;
         class_pending_ff <= class_pending_in;
         press_state_ff   <= press_state_in;
         last_repeat_ff   <= last_repeat_in;
         repeat_count_ff  <= repeat_count_in;
      end
   end

endmodule

FILE: hw/rtl/bpra_rsp_fifo.sv
// Four-entry response queue that takes up to two results per cycle.
// Depends on bpra_pkg for rsp_type and push_type.
module bpra_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_en,
   input  bpra_pkg::push_type push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bpra_pkg::rsp_type  rsp_data
);
   import bpra_pkg::*;

   localparam int CNT_BITS = FIFO_PTR + 1;

   rsp_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   add;
   logic                  pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid & rsp_ready;
   // keep space for the largest burst of results
   assign room      = (count_ff <= CNT_BITS'(FIFO_DEPTH - 2));
   assign add       = push_en ? CNT_BITS'(push.count) : '0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR'(add);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR'(pop);
      count_in  = count_ff + add - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_en && (push.count != 2'd0)) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push_en && (push.count == 2'd2)) begin
         mem_ff[wr_ptr_ff + FIFO_PTR'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hw/rtl/button_press_repeat_accel_unit.sv
// Top level of the button press classifier with accelerating auto-repeat.
// Depends on bpra_pkg, bpra_csr, bpra_core and bpra_rsp_fifo.
//
// Usage:
//   req_* carries one item per beat: a button sample (cmd 0) or a repeat
//   pass (cmd 1). rsp_* returns the results in order; a sample gives one
//   beat, a repeat pass zero to two beats, the last marked by last_of_run.
//   The APB port (psel..pready) holds the thresholds and step sizes; write
//   it only while no item is in flight. pready is always high.
//   Order: an accepted item is registered in the input register; it is processed
//   when the queue has room, and its results are valid once written to the queue.
//   Throughput: one item per cycle while the queue has room, set by the single
//   input register and state update; a two-result pass needs two output beats.
//   Stalls: results wait in a four-entry queue; the input register holds
//   its item while fewer than two entries are free, and req_ready drops
//   once that register is full and blocked.
//   Reset: synchronous; clears all button state and the queue and loads
//   the default register values. No clearing pass is needed.
module button_press_repeat_accel_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  bpra_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bpra_pkg::rsp_type              rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bpra_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import bpra_pkg::*;

   req_type  item_ff;
   logic     item_valid_ff, item_valid_in;
   cfg_type  cfg;
   push_type push;
   logic     room;
   logic     fire;

   assign fire          = item_valid_ff & room;
   assign req_ready     = ~item_valid_ff | fire;
   assign item_valid_in = (req_valid & req_ready) | (item_valid_ff & ~fire);

   // hold the beat until the queue has space for its results
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   bpra_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bpra_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (item_ff),
      .cfg   (cfg),
      .push  (push)
   );

   bpra_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (fire),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sim/bpra_press_checker.sv
`timescale 1ns / 100ps
// Checker for the button press repeat accelerator: watches the request, response and
// register ports, predicts every response beat and compares it. Depends on bpra_pkg.
module bpra_press_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  bpra_pkg::req_type              req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  bpra_pkg::rsp_type              rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [bpra_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output int                             error_total,
   output int                             results_outstanding
);
   import bpra_pkg::*;

   cfg_type         cfg;
   logic [31:0]     press_t     [NUM_BUTTONS];
   logic            held_lvl    [NUM_BUTTONS];
   logic            await_class [NUM_BUTTONS];
   press_class_type btn_class   [NUM_BUTTONS];
   logic [31:0]     repeat_t    [2];
   logic [4:0]      repeat_n    [2];
   rsp_type         results_due [$];
   int              mismatches = 0;
   int              due_count = 0;

   assign error_total         = mismatches;
   assign results_outstanding = due_count;

   function automatic logic [15:0] step_for(input int b, input logic [4:0] count);
      if (b == 0)
         return (count < MID_COUNT) ? cfg.first_step_slow :
                (count < FAST_COUNT) ? cfg.first_step_mid : cfg.first_step_fast;
      return (count < MID_COUNT) ? cfg.second_step_slow :
             (count < FAST_COUNT) ? cfg.second_step_mid : cfg.second_step_fast;
   endfunction

   function automatic bit field_ok(input string name, input logic [15:0] want,
                                   input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic apply_write(input logic [2:0] index, input logic [31:0] value);
      case (reg_index_type'(index))
         REG_LONG_THRESHOLD:   cfg.long_threshold   = value;
         REG_REPEAT_INTERVAL:  cfg.repeat_interval  = value;
         REG_FIRST_STEP_SLOW:  cfg.first_step_slow  = value[15:0];
         REG_FIRST_STEP_MID:   cfg.first_step_mid   = value[15:0];
         REG_FIRST_STEP_FAST:  cfg.first_step_fast  = value[15:0];
         REG_SECOND_STEP_SLOW: cfg.second_step_slow = value[15:0];
         REG_SECOND_STEP_MID:  cfg.second_step_mid  = value[15:0];
         REG_SECOND_STEP_FAST: cfg.second_step_fast = value[15:0];
         default: ;
      endcase
   endtask

   // Advance the button model by one request beat and queue the beats it must produce.
   task automatic update_buttons(input req_type r);
      rsp_type     o;
      rsp_type     burst [2];
      logic [31:0] age;
      logic [31:0] gap;
      int          b;
      int          n;
      o = '0;
      n = 0;
      if (r.cmd == CMD_SAMPLE) begin
         if (r.button_sel >= NUM_BUTTONS) begin
            o.kind         = KIND_BAD_INDEX;
            o.which_button = r.button_sel;
         end else begin
            b = r.button_sel;
            if (r.level && !held_lvl[b]) begin
               held_lvl[b]    = 1'b1;
               press_t[b]     = r.now_ticks;
               await_class[b] = 1'b1;
            end
            if (!r.level) begin
               held_lvl[b] = 1'b0;
               if (btn_class[b] == CLASS_LONG)
                  btn_class[b] = CLASS_OFF;
            end
            age = r.now_ticks - press_t[b];
            if (await_class[b] && age > cfg.long_threshold) begin
               await_class[b] = 1'b0;
               btn_class[b]   = r.level ? CLASS_LONG : CLASS_SHORT;
            end
            o.kind         = KIND_STATUS;
            o.which_button = r.button_sel;
            o.press_class  = btn_class[b];
         end
         o.last_of_run = 1'b1;
         results_due.push_back(o);
      end else begin
         for (b = 0; b < 2; b++) begin
            o              = '0;
            o.kind         = KIND_STEP;
            o.which_button = SEL_BITS'(b);
            if (btn_class[b] == CLASS_SHORT) begin
               btn_class[b]  = CLASS_OFF;
               o.press_class = CLASS_OFF;
               o.step_amount = step_for(b, '0);
               burst[n]      = o;
               n++;
            end else if (btn_class[b] == CLASS_LONG) begin
               gap = r.now_ticks - repeat_t[b];
               if (gap > cfg.repeat_interval) begin
                  o.press_class = CLASS_LONG;
                  o.step_amount = step_for(b, repeat_n[b]);
                  if (repeat_n[b] < FAST_COUNT)
                     repeat_n[b] = repeat_n[b] + 1'b1;
                  repeat_t[b] = r.now_ticks;
                  burst[n]    = o;
                  n++;
               end
            end else begin
               repeat_n[b] = '0;
            end
         end
         if (n > 0)
            burst[n-1].last_of_run = 1'b1;
         for (int i = 0; i < n; i++)
            results_due.push_back(burst[i]);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      bit      ok;
      if (reset) begin
         cfg.long_threshold   = 32'd1000;
         cfg.repeat_interval  = 32'd250;
         cfg.first_step_slow  = 16'd1;
         cfg.first_step_mid   = 16'd5;
         cfg.first_step_fast  = 16'd10;
         cfg.second_step_slow = 16'd1;
         cfg.second_step_mid  = 16'd2;
         cfg.second_step_fast = 16'd4;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            press_t[i]     = '0;
            held_lvl[i]    = 1'b0;
            await_class[i] = 1'b0;
            btn_class[i]   = CLASS_OFF;
         end
         for (int i = 0; i < 2; i++) begin
            repeat_t[i] = '0;
            repeat_n[i] = '0;
         end
         results_due.delete();
      end else begin
         if (psel && penable && pwrite && pready)
            apply_write(paddr[4:2], pwdata);
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $error("response beat with nothing expected: %h", rsp_data);
               mismatches++;
            end else begin
               want = results_due.pop_front();
               ok   = field_ok("kind", 16'(want.kind), 16'(rsp_data.kind));
               ok   = field_ok("which_button", 16'(want.which_button),
                               16'(rsp_data.which_button)) & ok;
               ok   = field_ok("press_class", 16'(want.press_class),
                               16'(rsp_data.press_class)) & ok;
               ok   = field_ok("step_amount", want.step_amount, rsp_data.step_amount) & ok;
               ok   = field_ok("last_of_run", 16'(want.last_of_run),
                               16'(rsp_data.last_of_run)) & ok;
               if (!ok)
                  mismatches++;
            end
         end
         if (req_valid && req_ready)
            update_buttons(req_data);
      end
      due_count = results_due.size();
   end

endmodule

FILE: sim/tb_button_press_repeat_accel_unit.sv
`timescale 1ns / 100ps
// Testbench top for button_press_repeat_accel_unit: drives requests, register writes
// and response back-pressure, and gives the verdict. Depends on bpra_pkg and bpra_press_checker.
module tb_button_press_repeat_accel_unit;
   import bpra_pkg::*;

   localparam int IDLE_PCT        = 21;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 6;
   localparam int PHASES          = 8;
   localparam int PHASE_ITEMS     = 172;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [ADDR_BITS-1:0] paddr = '0;
   logic [31:0]          pwdata = '0;
   logic [31:0]          prdata;
   logic                 pready;

   int          error_total;
   int          results_outstanding;
   int          stall_cycles = 0;
   int          hold_off_asks = 0;
   int          hold_off_served = 0;
   int          hold_off_left = 0;
   bit          quiet_sender = 1'b0;
   bit          quiet_receiver = 1'b0;
   logic [31:0] tick_now = '0;
   bit          held [NUM_BUTTONS];
   int          hold_odds = 10;
   int          jump_max = 8;
   logic [31:0] reg_vals [8];

   button_press_repeat_accel_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   bpra_press_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data            (req_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_data            (rsp_data),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .pready              (pready),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .error_total         (error_total),
      .results_outstanding (results_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Response side: random back-pressure, plus a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_ready     <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else if (hold_off_served < hold_off_asks) begin
         rsp_ready       <= 1'b0;
         hold_off_left   <= HOLD_OFF_CYCLES;
         hold_off_served <= hold_off_served + 1;
      end else begin
         rsp_ready <= quiet_receiver || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_beat(input req_type item);
      while (!quiet_sender && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic send_fields(input cmd_type cmd, input logic [1:0] sel, input logic lvl,
                              input logic [31:0] t);
      req_type item;
      item.cmd        = cmd;
      item.button_sel = sel;
      item.level      = lvl;
      item.now_ticks  = t;
      send_beat(item);
   endtask

   // Mostly coherent press/hold/release sequences per button, mixed with repeat passes;
   // a few level glitches, out-of-range indexes and timestamp jumps.
   task automatic next_item(output req_type item);
      int pick;
      int b;
      item = '0;
      if ($urandom_range(99) < 4)
         tick_now = $urandom();
      else
         tick_now = tick_now + $urandom_range(jump_max);
      item.now_ticks = tick_now;
      pick = $urandom_range(99);
      if (pick < 35) begin
         item.cmd        = CMD_REPEAT;
         item.button_sel = SEL_BITS'($urandom_range(3));
         item.level      = 1'($urandom_range(1));
      end else if (pick < 38) begin
         item.cmd        = CMD_SAMPLE;
         item.button_sel = SEL_BITS'($urandom_range(3, NUM_BUTTONS));
         item.level      = 1'($urandom_range(1));
      end else begin
         b = $urandom_range(NUM_BUTTONS - 1);
         if ($urandom_range(99) < hold_odds)
            held[b] = !held[b];
         item.cmd        = CMD_SAMPLE;
         item.button_sel = SEL_BITS'(b);
         item.level      = ($urandom_range(99) < 8) ? !held[b] : held[b];
      end
   endtask

   // Called on a clock edge; leaves psel high so back-to-back writes need one assignment per step.
   task automatic write_reg(input reg_index_type index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
   endtask

   task automatic write_config();
      for (int i = 0; i < 8; i++)
         write_reg(reg_index_type'(i), reg_vals[i]);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (results_outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      req_type item;
      for (int i = 0; i < NUM_BUTTONS; i++)
         held[i] = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset register values: threshold 1000, interval 250.
      send_fields(CMD_SAMPLE, 2'd3, 1'b1, 32'hFFFF_FFFF);   // out-of-range index
      send_fields(CMD_REPEAT, 2'd0, 1'b0, 32'd0);           // nothing to repeat
      send_fields(CMD_SAMPLE, 2'd0, 1'b1, 32'd100);
      send_fields(CMD_SAMPLE, 2'd0, 1'b1, 32'd1100);        // age equals threshold: no class
      send_fields(CMD_SAMPLE, 2'd0, 1'b1, 32'd1101);        // long
      send_fields(CMD_REPEAT, 2'd3, 1'b1, 32'd1400);
      send_fields(CMD_REPEAT, 2'd0, 1'b0, 32'd1500);        // interval not yet elapsed
      send_fields(CMD_SAMPLE, 2'd1, 1'b1, 32'd1600);
      send_fields(CMD_SAMPLE, 2'd1, 1'b0, 32'd1700);
      send_fields(CMD_SAMPLE, 2'd1, 1'b0, 32'd2601);        // short
      send_fields(CMD_REPEAT, 2'd0, 1'b0, 32'd2700);        // two beats
      send_fields(CMD_SAMPLE, 2'd2, 1'b1, 32'd3000);
      send_fields(CMD_SAMPLE, 2'd2, 1'b0, 32'd3100);
      send_fields(CMD_SAMPLE, 2'd2, 1'b0, 32'd4101);        // third button short stays latched
      send_fields(CMD_REPEAT, 2'd0, 1'b0, 32'd4200);
      send_fields(CMD_SAMPLE, 2'd0, 1'b0, 32'd4300);        // release drops long
      send_fields(CMD_REPEAT, 2'd0, 1'b0, 32'd4400);
      send_fields(CMD_SAMPLE, 2'd0, 1'b1, 32'hFFFF_FF00);
      send_fields(CMD_SAMPLE, 2'd0, 1'b1, 32'h0000_03F0);   // press age across the wrap
      send_fields(CMD_REPEAT, 2'd1, 1'b1, 32'h0000_0500);
      send_fields(CMD_SAMPLE, 2'd1, 1'b1, 32'd0);
      send_fields(CMD_SAMPLE, 2'd2, 1'b0, 32'h7FFF_FFFF);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0: begin
               reg_vals[0] = '0;
               reg_vals[1] = '0;
               for (int i = 2; i < 8; i++)
                  reg_vals[i] = 32'hFFFF_FFFF;
            end
            1: begin
               reg_vals[0] = 32'hFFFF_FFFF;
               reg_vals[1] = 32'hFFFF_FFFF;
               for (int i = 2; i < 8; i++)
                  reg_vals[i] = 32'hFFFF_0000;
            end
            default: begin
               reg_vals[0] = $urandom_range(80);
               reg_vals[1] = $urandom_range(40);
               for (int i = 2; i < 8; i++)
                  reg_vals[i] = $urandom();
            end
         endcase
         write_config();
         hold_odds      = $urandom_range(20, 3);
         jump_max       = (phase % 3 == 0) ? 3 : 8;
         quiet_sender   = (phase == 4);
         quiet_receiver = (phase == 4);
         tick_now       = $urandom();
         if (phase == 2 || phase == 6)
            hold_off_asks <= hold_off_asks + 1;
         repeat (PHASE_ITEMS) begin
            next_item(item);
            send_beat(item);
         end
      end
      drain();

      if (error_total == 0 && results_outstanding == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
